### rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and fixed-point helpers
// Word types, region codes and saturating Q16.16 arithmetic for the
// closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int CW = 32;                  // coordinate width
  localparam int FB = 16;                  // fraction bits
  localparam int DIV_QB = CW - 1;          // quotient bits produced by the divider
  localparam int DIV_LAT = DIV_QB + 2;     // divider pipeline depth in enabled registers

  typedef logic signed [CW-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam fx_t FX_ONE = fx_t'(64'd1 << FB);

  typedef enum logic [1:0] {
    REG_FACE = 2'd0,
    REG_AB   = 2'd1,
    REG_AC   = 2'd2,
    REG_BC   = 2'd3
  } region_t;

  typedef struct packed {
    fx_t query_x;
    fx_t query_y;
    fx_t query_z;
    fx_t vert_a_x;
    fx_t vert_a_y;
    fx_t vert_a_z;
    fx_t vert_b_x;
    fx_t vert_b_y;
    fx_t vert_b_z;
    fx_t vert_c_x;
    fx_t vert_c_y;
    fx_t vert_c_z;
  } cpt_in_t;

  typedef struct packed {
    fx_t     near_x;
    fx_t     near_y;
    fx_t     near_z;
    region_t region;
    logic    degenerate;
  } cpt_out_t;

  typedef struct packed {
    fx_t x;
    fx_t y;
    fx_t z;
  } vec_t;

  // the six partial products of a cross product
  typedef struct packed {
    fx_t xl, xr, yl, yr, zl, zr;
  } xprod_t;

  function automatic fx_t clamp33(logic signed [CW:0] s);
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? FX_MIN : FX_MAX;
    end
    return fx_t'(s[CW-1:0]);
  endfunction

  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    return clamp33(s);
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} - {b[CW-1], b};
    return clamp33(s);
  endfunction

  // exact product, truncate toward zero by FB, saturate
  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic [2*CW-1:0]    p;
    logic [2*CW-1:0]    m;
    logic [2*CW-FB-1:0] sh;
    logic               neg;
    p   = {{CW{a[CW-1]}}, a} * {{CW{b[CW-1]}}, b};
    neg = p[2*CW-1];
    m   = neg ? (~p + 1'b1) : p;
    sh  = m[2*CW-1:FB];
    if (!neg) begin
      return (sh > (2*CW-FB)'(FX_MAX)) ? FX_MAX : fx_t'(sh[CW-1:0]);
    end
    return (sh >= (2*CW-FB)'({1'b1, {(CW-1){1'b0}}})) ? FX_MIN :
           fx_t'(~sh[CW-1:0] + 1'b1);
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = sat_sub(a.x, b.x);
    r.y = sat_sub(a.y, b.y);
    r.z = sat_sub(a.z, b.z);
    return r;
  endfunction

  function automatic vec_t vadd(vec_t a, vec_t b);
    vec_t r;
    r.x = sat_add(a.x, b.x);
    r.y = sat_add(a.y, b.y);
    r.z = sat_add(a.z, b.z);
    return r;
  endfunction

  function automatic vec_t vscale(vec_t a, fx_t t);
    vec_t r;
    r.x = fx_mul(a.x, t);
    r.y = fx_mul(a.y, t);
    r.z = fx_mul(a.z, t);
    return r;
  endfunction

  // componentwise products of a dot product
  function automatic vec_t dot_mul(vec_t a, vec_t b);
    vec_t r;
    r.x = fx_mul(a.x, b.x);
    r.y = fx_mul(a.y, b.y);
    r.z = fx_mul(a.z, b.z);
    return r;
  endfunction

  function automatic fx_t dot_fin(vec_t p);
    return sat_add(sat_add(p.x, p.y), p.z);
  endfunction

  function automatic xprod_t cross_mul(vec_t a, vec_t b);
    xprod_t r;
    r.xl = fx_mul(a.y, b.z);
    r.xr = fx_mul(a.z, b.y);
    r.yl = fx_mul(a.z, b.x);
    r.yr = fx_mul(a.x, b.z);
    r.zl = fx_mul(a.x, b.y);
    r.zr = fx_mul(a.y, b.x);
    return r;
  endfunction

  function automatic vec_t cross_fin(xprod_t p);
    vec_t r;
    r.x = sat_sub(p.xl, p.xr);
    r.y = sat_sub(p.yl, p.yr);
    r.z = sat_sub(p.zl, p.zr);
    return r;
  endfunction

endpackage

### rtl/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div: pipelined fixed-point divider
// Signed numerator over positive denominator, one quotient bit per stage,
// truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module cpt_div (
  input  logic         clk,
  input  logic         en,
  input  cpt_pkg::fx_t num,
  input  cpt_pkg::fx_t den,
  output cpt_pkg::fx_t quot
);
  import cpt_pkg::*;

  localparam int RW = CW + FB;   // partial remainder width
  localparam int TW = 2 * CW;    // shifted divisor width

  logic [RW-1:0]     rem_r   [0:DIV_QB];
  logic [DIV_QB-1:0] quo_r   [0:DIV_QB];
  logic [CW-1:0]     den_r   [0:DIV_QB];
  logic              neg_r   [0:DIV_QB];
  logic              ovf_r   [0:DIV_QB];
  logic [RW-1:0]     rem_nxt [0:DIV_QB-1];
  logic [DIV_QB-1:0] quo_nxt [0:DIV_QB-1];
  logic [CW-1:0]     mag_w;
  logic [CW-1:0]     q_w;
  fx_t               quot_nxt;

  assign mag_w = num[CW-1] ? (CW'(~num) + 1'b1) : CW'(num);

  // one restoring step per stage, MSB first
  always_comb begin
    logic [TW-1:0] trial;
    for (int k = 0; k < DIV_QB; k++) begin
      trial = {{(TW-CW){1'b0}}, den_r[k]} << (DIV_QB - 1 - k);
      if ({{(TW-RW){1'b0}}, rem_r[k]} >= trial) begin
        rem_nxt[k] = rem_r[k] - trial[RW-1:0];
        quo_nxt[k] = quo_r[k] | (DIV_QB'(1) << (DIV_QB - 1 - k));
      end else begin
        rem_nxt[k] = rem_r[k];
        quo_nxt[k] = quo_r[k];
      end
    end
  end

  always_comb begin
    q_w = {1'b0, quo_r[DIV_QB]};
    if (ovf_r[DIV_QB]) begin
      quot_nxt = neg_r[DIV_QB] ? FX_MIN : FX_MAX;
    end else begin
      quot_nxt = neg_r[DIV_QB] ? fx_t'(~q_w + 1'b1) : fx_t'(q_w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {mag_w, {FB{1'b0}}};
      quo_r[0] <= '0;
      den_r[0] <= CW'(den);
      neg_r[0] <= num[CW-1];
      // integer part beyond the signed range saturates
      ovf_r[0] <= {{FB{1'b0}}, mag_w} >= {1'b0, CW'(den), {(FB-1){1'b0}}};
      for (int k = 0; k < DIV_QB; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        quo_r[k+1] <= quo_nxt[k];
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
      quot <= quot_nxt;
    end
  end

endmodule

### rtl/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle: nearest point of a 3D triangle to a query point
// Deep pipeline over signed Q16.16 coordinates with saturating arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one query word: the
//   query point and the three vertices. Output channel (out_valid /
//   out_stall / out_word) returns one word per query, in order: the nearest
//   point, the region code and the degenerate flag.
// Pipeline: the depth is set by the 33-stage pipelined divider (one quotient
//   bit a stage) plus the stages of multiply, add and compare around it.
// Throughput: one word per cycle while in_stall is low; a new query may enter every cycle that in_stall is low.
// Stall: out_word sits in an output register with a one-word skid register
//   behind it. While the receiver stalls, the pipeline keeps moving until the
//   skid register fills; only then is in_stall raised (straight from a flop)
//   and the whole pipeline freezes. Nothing is dropped or repeated.
// Reset: rst_n low clears every valid bit and the skid; the block takes a
//   query as soon as reset is released.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cpt_pkg::cpt_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output cpt_pkg::cpt_out_t out_word
);
  import cpt_pkg::*;

  // state carried alongside the dividers
  typedef struct packed {
    vec_t       q;
    vec_t       a;
    vec_t       b;
    vec_t       e1;
    vec_t       e2;
    vec_t       e3;
    vec_t       n;
    logic [2:0] tz;      // edge param clamps to 0
    logic [2:0] tone;    // edge param clamps to 1
    logic       in_face;
    logic       degen;
  } cpt_side_t;

  logic en;   // global advance

  // stage 0: input capture
  cpt_in_t in_r;
  logic    v0_r;
  vec_t    q0, a0, b0, c0;

  // stage 1: differences
  vec_t q1_r, a1_r, b1_r, e1_1_r, e2_1_r, e3_1_r, wa1_r, cq1_r, qb1_r;
  logic v1_r;

  // stage 2: first products
  vec_t   q2_r, a2_r, b2_r, e1_2_r, e2_2_r, e3_2_r, wa2_r;
  xprod_t xn2_r, xg1_2_r, xg2_2_r, xg3_2_r;
  vec_t   pl1_2_r, pl2_2_r, pl3_2_r, pd1_2_r, pd2_2_r, pd3_2_r;
  logic   v2_r;

  // stage 3: normal, cross terms, lengths, edge dots
  vec_t q3_r, a3_r, b3_r, e1_3_r, e2_3_r, e3_3_r, wa3_r, n3_r;
  vec_t x1_3_r, x2_3_r, x3_3_r;
  fx_t  l1_3_r, l2_3_r, l3_3_r, d1_3_r, d2_3_r, d3_3_r;
  logic v3_r;

  // stage 4: second products
  vec_t q4_r, a4_r, b4_r, e1_4_r, e2_4_r, e3_4_r, n4_r;
  fx_t  l1_4_r, l2_4_r, l3_4_r, d1_4_r, d2_4_r, d3_4_r;
  vec_t pnn4_r, pg1_4_r, pg2_4_r, pg3_4_r, psn4_r;
  logic v4_r;

  // stage 5: sums, tests, divider operands
  fx_t       nn5, sn5;
  cpt_side_t side5_r;
  fx_t       div_num_r [0:3];
  fx_t       div_den_r [0:3];
  fx_t       quot      [0:3];
  logic      v5_r;

  // divider alignment
  cpt_side_t          sd_r [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] dv_r;
  cpt_side_t          sd;
  fx_t                t1, t2, t3;

  // stage 6: scale by quotients
  vec_t q6_r, a6_r, b6_r, fp6_r, ep1_6_r, ep2_6_r, ep3_6_r;
  logic inside6_r, degen6_r, v6_r;

  // stage 7: candidates
  vec_t q7_r, a7_r, face7_r, p1_7_r, p2_7_r, p3_7_r;
  logic inside7_r, degen7_r, v7_r;

  // stage 8: offsets to the query
  vec_t a8_r, face8_r, p1_8_r, p2_8_r, p3_8_r, dd1_8_r, dd2_8_r, dd3_8_r;
  logic inside8_r, degen8_r, v8_r;

  // stage 9: squared-distance products
  vec_t a9_r, face9_r, p1_9_r, p2_9_r, p3_9_r, sq1_9_r, sq2_9_r, sq3_9_r;
  logic inside9_r, degen9_r, v9_r;

  // stage 10: squared distances
  vec_t a10_r, face10_r, p1_10_r, p2_10_r, p3_10_r;
  fx_t  s1_10_r, s2_10_r, s3_10_r;
  logic inside10_r, degen10_r, v10_r;

  // output register and skid
  cpt_out_t res_w;
  vec_t     rv;
  cpt_out_t out_r, skid_r;
  logic     out_valid_r, skid_v_r;
  logic     take;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  assign q0 = {in_r.query_x, in_r.query_y, in_r.query_z};
  assign a0 = {in_r.vert_a_x, in_r.vert_a_y, in_r.vert_a_z};
  assign b0 = {in_r.vert_b_x, in_r.vert_b_y, in_r.vert_b_z};
  assign c0 = {in_r.vert_c_x, in_r.vert_c_y, in_r.vert_c_z};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      dv_r  <= '0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v0_r  <= in_valid;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      dv_r  <= {dv_r[DIV_LAT-2:0], v5_r};
      v6_r  <= dv_r[DIV_LAT-1];
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  // front half: edges, normal, lengths and edge dots
  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_word;

      q1_r   <= q0;
      a1_r   <= a0;
      b1_r   <= b0;
      e1_1_r <= vsub(b0, a0);
      e2_1_r <= vsub(c0, a0);
      e3_1_r <= vsub(c0, b0);
      wa1_r  <= vsub(q0, a0);
      cq1_r  <= vsub(c0, q0);
      qb1_r  <= vsub(q0, b0);

      q2_r    <= q1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      e1_2_r  <= e1_1_r;
      e2_2_r  <= e2_1_r;
      e3_2_r  <= e3_1_r;
      wa2_r   <= wa1_r;
      xn2_r   <= cross_mul(e1_1_r, e2_1_r);
      xg1_2_r <= cross_mul(e1_1_r, wa1_r);
      xg2_2_r <= cross_mul(e2_1_r, cq1_r);
      xg3_2_r <= cross_mul(e3_1_r, qb1_r);
      pl1_2_r <= dot_mul(e1_1_r, e1_1_r);
      pl2_2_r <= dot_mul(e2_1_r, e2_1_r);
      pl3_2_r <= dot_mul(e3_1_r, e3_1_r);
      pd1_2_r <= dot_mul(e1_1_r, wa1_r);
      pd2_2_r <= dot_mul(e2_1_r, wa1_r);
      pd3_2_r <= dot_mul(e3_1_r, qb1_r);

      q3_r   <= q2_r;
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      e1_3_r <= e1_2_r;
      e2_3_r <= e2_2_r;
      e3_3_r <= e3_2_r;
      wa3_r  <= wa2_r;
      n3_r   <= cross_fin(xn2_r);
      x1_3_r <= cross_fin(xg1_2_r);
      x2_3_r <= cross_fin(xg2_2_r);
      x3_3_r <= cross_fin(xg3_2_r);
      l1_3_r <= dot_fin(pl1_2_r);
      l2_3_r <= dot_fin(pl2_2_r);
      l3_3_r <= dot_fin(pl3_2_r);
      d1_3_r <= dot_fin(pd1_2_r);
      d2_3_r <= dot_fin(pd2_2_r);
      d3_3_r <= dot_fin(pd3_2_r);

      q4_r    <= q3_r;
      a4_r    <= a3_r;
      b4_r    <= b3_r;
      e1_4_r  <= e1_3_r;
      e2_4_r  <= e2_3_r;
      e3_4_r  <= e3_3_r;
      n4_r    <= n3_r;
      l1_4_r  <= l1_3_r;
      l2_4_r  <= l2_3_r;
      l3_4_r  <= l3_3_r;
      d1_4_r  <= d1_3_r;
      d2_4_r  <= d2_3_r;
      d3_4_r  <= d3_3_r;
      pnn4_r  <= dot_mul(n3_r, n3_r);
      pg1_4_r <= dot_mul(x1_3_r, n3_r);
      pg2_4_r <= dot_mul(x2_3_r, n3_r);
      pg3_4_r <= dot_mul(x3_3_r, n3_r);
      psn4_r  <= dot_mul(n3_r, wa3_r);
    end
  end

  assign nn5 = dot_fin(pnn4_r);
  assign sn5 = dot_fin(psn4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r.q       <= q4_r;
      side5_r.a       <= a4_r;
      side5_r.b       <= b4_r;
      side5_r.e1      <= e1_4_r;
      side5_r.e2      <= e2_4_r;
      side5_r.e3      <= e3_4_r;
      side5_r.n       <= n4_r;
      side5_r.tz      <= {d3_4_r <= 0, d2_4_r <= 0, d1_4_r <= 0};
      side5_r.tone    <= {d3_4_r >= l3_4_r, d2_4_r >= l2_4_r, d1_4_r >= l1_4_r};
      // strictly inside every edge
      side5_r.in_face <= (dot_fin(pg1_4_r) > 0) && (dot_fin(pg2_4_r) > 0) &&
                         (dot_fin(pg3_4_r) > 0);
      // zero-length edge or zero normal, after underflow
      side5_r.degen   <= (l1_4_r <= 0) || (l2_4_r <= 0) || (l3_4_r <= 0) ||
                         (nn5 <= 0);
      div_num_r[0]    <= sn5;
      div_den_r[0]    <= nn5;
      div_num_r[1]    <= d1_4_r;
      div_den_r[1]    <= l1_4_r;
      div_num_r[2]    <= d2_4_r;
      div_den_r[2]    <= l2_4_r;
      div_num_r[3]    <= d3_4_r;
      div_den_r[3]    <= l3_4_r;
    end
  end

  // lane 0: plane offset, lanes 1..3: edge parameters
  for (genvar g = 0; g < 4; g++) begin : g_div
    cpt_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (div_num_r[g]),
      .den  (div_den_r[g]),
      .quot (quot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side5_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  assign sd = sd_r[DIV_LAT-1];
  assign t1 = sd.tz[0] ? '0 : (sd.tone[0] ? FX_ONE : quot[1]);
  assign t2 = sd.tz[1] ? '0 : (sd.tone[1] ? FX_ONE : quot[2]);
  assign t3 = sd.tz[2] ? '0 : (sd.tone[2] ? FX_ONE : quot[3]);

  // back half: candidates and distances
  always_ff @(posedge clk) begin
    if (en) begin
      q6_r      <= sd.q;
      a6_r      <= sd.a;
      b6_r      <= sd.b;
      fp6_r     <= vscale(sd.n, quot[0]);
      ep1_6_r   <= vscale(sd.e1, t1);
      ep2_6_r   <= vscale(sd.e2, t2);
      ep3_6_r   <= vscale(sd.e3, t3);
      inside6_r <= sd.in_face;
      degen6_r  <= sd.degen;

      q7_r      <= q6_r;
      a7_r      <= a6_r;
      face7_r   <= vsub(q6_r, fp6_r);
      p1_7_r    <= vadd(a6_r, ep1_6_r);
      p2_7_r    <= vadd(a6_r, ep2_6_r);
      p3_7_r    <= vadd(b6_r, ep3_6_r);
      inside7_r <= inside6_r;
      degen7_r  <= degen6_r;

      a8_r      <= a7_r;
      face8_r   <= face7_r;
      p1_8_r    <= p1_7_r;
      p2_8_r    <= p2_7_r;
      p3_8_r    <= p3_7_r;
      dd1_8_r   <= vsub(q7_r, p1_7_r);
      dd2_8_r   <= vsub(q7_r, p2_7_r);
      dd3_8_r   <= vsub(q7_r, p3_7_r);
      inside8_r <= inside7_r;
      degen8_r  <= degen7_r;

      a9_r      <= a8_r;
      face9_r   <= face8_r;
      p1_9_r    <= p1_8_r;
      p2_9_r    <= p2_8_r;
      p3_9_r    <= p3_8_r;
      sq1_9_r   <= dot_mul(dd1_8_r, dd1_8_r);
      sq2_9_r   <= dot_mul(dd2_8_r, dd2_8_r);
      sq3_9_r   <= dot_mul(dd3_8_r, dd3_8_r);
      inside9_r <= inside8_r;
      degen9_r  <= degen8_r;

      a10_r      <= a9_r;
      face10_r   <= face9_r;
      p1_10_r    <= p1_9_r;
      p2_10_r    <= p2_9_r;
      p3_10_r    <= p3_9_r;
      s1_10_r    <= dot_fin(sq1_9_r);
      s2_10_r    <= dot_fin(sq2_9_r);
      s3_10_r    <= dot_fin(sq3_9_r);
      inside10_r <= inside9_r;
      degen10_r  <= degen9_r;
    end
  end

  // pick the answer; ties favor the later edge
  always_comb begin
    res_w.degenerate = 1'b0;
    res_w.region     = REG_FACE;
    rv               = face10_r;
    if (degen10_r) begin
      rv               = a10_r;
      res_w.degenerate = 1'b1;
    end else if (inside10_r) begin
      rv = face10_r;
    end else if ((s1_10_r < s2_10_r) && (s1_10_r < s3_10_r)) begin
      rv           = p1_10_r;
      res_w.region = REG_AB;
    end else if (!(s1_10_r < s2_10_r) && (s2_10_r < s3_10_r)) begin
      rv           = p2_10_r;
      res_w.region = REG_AC;
    end else begin
      rv           = p3_10_r;
      res_w.region = REG_BC;
    end
    res_w.near_x = rv.x;
    res_w.near_y = rv.y;
    res_w.near_z = rv.z;
  end

  // output register with one-word skid
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (v10_r) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (v10_r) begin
      if (!out_valid_r || take) begin
        out_r <= res_w;
      end else begin
        skid_r <= res_w;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### rtl/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker: port-level checks for closest_point_on_triangle
// Watches the handshakes and result words over time.
// ----------------------------------------------------------------------------
module cpt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input cpt_pkg::cpt_out_t out_word
);
  import cpt_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // input is only held off while a result waits
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // degenerate triangles report the face region
  a_degen_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.degenerate |-> out_word.region == REG_FACE)
    else $error("degenerate word with edge region");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not cleared by reset");

endmodule

bind closest_point_on_triangle cpt_checker u_cpt_checker (.*);

### tb/closest_point_on_triangle_test.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle_test: self-checking bench for the triangle block
// Drives query words, predicts the nearest point with a saturating Q16.16
// model and compares every output word in order, under several idle mixes.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  // ---- saturating fixed-point arithmetic for prediction ---------------------
  function automatic fx_t q_sat(logic signed [127:0] v);
    if (v > 128'sd2147483647) return FX_MAX;
    if (v < -128'sd2147483648) return FX_MIN;
    return fx_t'(v[31:0]);
  endfunction

  function automatic fx_t q_add(fx_t a, fx_t b);
    return q_sat(128'(signed'(a)) + 128'(signed'(b)));
  endfunction

  function automatic fx_t q_sub(fx_t a, fx_t b);
    return q_sat(128'(signed'(a)) - 128'(signed'(b)));
  endfunction

  // exact product, truncated toward zero by the fraction bits
  function automatic fx_t q_mul(fx_t a, fx_t b);
    logic signed [127:0] p;
    logic [127:0] m;
    p = 128'(signed'(a)) * 128'(signed'(b));
    m = p < 0 ? 128'(-p) : 128'(p);
    m = m >> FB;
    return q_sat(p < 0 ? -$signed(m) : $signed(m));
  endfunction

  // quotient num/den with den > 0, truncated toward zero
  function automatic fx_t q_div(fx_t num, fx_t den);
    logic signed [127:0] n;
    logic [127:0] m, qt;
    n = 128'(signed'(num));
    m = n < 0 ? 128'(-n) : 128'(n);
    qt = (m << FB) / 128'(signed'(den));
    return q_sat(n < 0 ? -$signed(qt) : $signed(qt));
  endfunction

  function automatic void v_sub(input fx_t a[3], input fx_t b[3], output fx_t r[3]);
    for (int i = 0; i < 3; i++) r[i] = q_sub(a[i], b[i]);
  endfunction

  function automatic fx_t v_dot(input fx_t a[3], input fx_t b[3]);
    return q_add(q_add(q_mul(a[0], b[0]), q_mul(a[1], b[1])), q_mul(a[2], b[2]));
  endfunction

  function automatic void v_cross(input fx_t a[3], input fx_t b[3], output fx_t r[3]);
    r[0] = q_sub(q_mul(a[1], b[2]), q_mul(a[2], b[1]));
    r[1] = q_sub(q_mul(a[2], b[0]), q_mul(a[0], b[2]));
    r[2] = q_sub(q_mul(a[0], b[1]), q_mul(a[1], b[0]));
  endfunction

  // clamped projection of the query onto one edge segment
  function automatic void edge_clamp(input fx_t q[3], input fx_t p0[3], input fx_t e[3],
                                     input fx_t len2, output fx_t r[3]);
    fx_t w[3];
    fx_t d, t;
    v_sub(q, p0, w);
    d = v_dot(e, w);
    if (d <= 0) t = '0;
    else if (d >= len2) t = FX_ONE;
    else t = q_div(d, len2);
    for (int i = 0; i < 3; i++) r[i] = q_add(p0[i], q_mul(e[i], t));
  endfunction

  function automatic cpt_out_t nearest_point(cpt_in_t w);
    fx_t q[3], a[3], b[3], c[3], e1[3], e2[3], e3[3], n[3], res[3];
    fx_t wa[3], tmp[3], cr[3], p1[3], p2[3], p3[3], d1[3], d2[3], d3[3];
    fx_t l1, l2, l3, nn, s, s1, s2, s3;
    logic in1, in2, in3;
    cpt_out_t o;
    q = '{w.query_x, w.query_y, w.query_z};
    a = '{w.vert_a_x, w.vert_a_y, w.vert_a_z};
    b = '{w.vert_b_x, w.vert_b_y, w.vert_b_z};
    c = '{w.vert_c_x, w.vert_c_y, w.vert_c_z};
    o.region = REG_FACE;
    o.degenerate = 1'b0;
    v_sub(b, a, e1);
    v_sub(c, a, e2);
    v_sub(c, b, e3);
    v_cross(e1, e2, n);
    l1 = v_dot(e1, e1);
    l2 = v_dot(e2, e2);
    l3 = v_dot(e3, e3);
    nn = v_dot(n, n);
    if (l1 <= 0 || l2 <= 0 || l3 <= 0 || nn <= 0) begin
      res = a;
      o.degenerate = 1'b1;
    end else begin
      v_sub(q, a, wa);
      v_cross(e1, wa, cr);
      in1 = v_dot(cr, n) > 0;
      v_sub(c, q, tmp);
      v_cross(e2, tmp, cr);
      in2 = v_dot(cr, n) > 0;
      v_sub(q, b, tmp);
      v_cross(e3, tmp, cr);
      in3 = v_dot(cr, n) > 0;
      if (in1 && in2 && in3) begin
        s = q_div(v_dot(n, wa), nn);
        for (int i = 0; i < 3; i++) res[i] = q_sub(q[i], q_mul(n[i], s));
      end else begin
        edge_clamp(q, a, e1, l1, p1);
        edge_clamp(q, a, e2, l2, p2);
        edge_clamp(q, b, e3, l3, p3);
        v_sub(q, p1, d1);
        v_sub(q, p2, d2);
        v_sub(q, p3, d3);
        s1 = v_dot(d1, d1);
        s2 = v_dot(d2, d2);
        s3 = v_dot(d3, d3);
        // later edge wins ties
        if (s1 < s2 && s1 < s3) begin
          res = p1;
          o.region = REG_AB;
        end else if (!(s1 < s2) && s2 < s3) begin
          res = p2;
          o.region = REG_AC;
        end else begin
          res = p3;
          o.region = REG_BC;
        end
      end
    end
    o.near_x = res[0];
    o.near_y = res[1];
    o.near_z = res[2];
    return o;
  endfunction

  // ---- scoreboard ------------------------------------------------------------
  class nearest_scoreboard;
    cpt_out_t pending[$];
    int mismatches = 0;

    function void note_query(cpt_in_t w);
      pending = {pending, nearest_point(w)};
    endfunction

    function void check_word(cpt_out_t got);
      cpt_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
          got.near_z !== want.near_z || got.region !== want.region ||
          got.degenerate !== want.degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%h y=%h z=%h r=%0d d=%b got x=%h y=%h z=%h r=%0d d=%b",
                   want.near_x, want.near_y, want.near_z, want.region, want.degenerate,
                   got.near_x, got.near_y, got.near_z, got.region, got.degenerate);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  cpt_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  cpt_out_t out_word;

  nearest_scoreboard board;
  int  send_idle_pct;      // sender idle odds, percent
  int  recv_stall_pct;     // receiver stall odds, percent
  bit  hold_off;           // long receiver hold-off in progress
  bit  sending_done;
  int  quiet_cycles;

  closest_point_on_triangle DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- stimulus shapes -------------------------------------------------------
  function automatic fx_t rand_coord();
    case ($urandom_range(0, 5))
      0: return fx_t'($urandom);                                 // full range
      1: return fx_t'($urandom_range(0, 3) == 0 ? FX_MAX : FX_MIN);
      2: return fx_t'(int'($urandom_range(0, 2000)) - 1000);     // sub-unit
      default: return fx_t'((int'($urandom_range(0, 40)) - 20) * 65536 +
                            int'($urandom_range(0, 65535)));     // a few units
    endcase
  endfunction

  function automatic cpt_in_t rand_query();
    cpt_in_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 9) != 0) begin
      // mostly moderate geometry so all regions and the face case show up
      w.query_x = rand_coord(); w.query_y = rand_coord(); w.query_z = rand_coord();
      w.vert_a_x = rand_coord(); w.vert_a_y = rand_coord(); w.vert_a_z = rand_coord();
      w.vert_b_x = rand_coord(); w.vert_b_y = rand_coord(); w.vert_b_z = rand_coord();
      w.vert_c_x = rand_coord(); w.vert_c_y = rand_coord(); w.vert_c_z = rand_coord();
      if ($urandom_range(0, 3) == 0) begin
        // query near the triangle's plane: face hits
        w.query_z = w.vert_a_z;
        w.vert_b_z = w.vert_a_z;
        w.vert_c_z = w.vert_a_z;
      end
      if ($urandom_range(0, 15) == 0) begin
        w.vert_b_x = w.vert_a_x; w.vert_b_y = w.vert_a_y; w.vert_b_z = w.vert_a_z;
      end
    end
    return w;
  endfunction

  function automatic fx_t unit(int v);
    return fx_t'(v * 65536);
  endfunction

  // ---- driving ---------------------------------------------------------------
  // valid stays up after an accept; it drops only for idle cycles
  task automatic send_query(cpt_in_t w);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_query(w);
  endtask

  task automatic send_directed();
    cpt_in_t w;
    // right triangle with legs of four units in z=0: face, each edge region, corners
    w = '{unit(0), unit(0), unit(1), unit(0), unit(0), unit(0),
          unit(4), unit(0), unit(0), unit(0), unit(4), unit(0)};
    send_query(w);                                   // above vertex a: tie, edge a-c
    w.query_x = unit(1); w.query_y = unit(1); send_query(w);       // face
    w.query_x = unit(2); w.query_y = -unit(3); send_query(w);      // edge a-b
    w.query_x = -unit(3); w.query_y = unit(2); send_query(w);      // edge a-c
    w.query_x = unit(5); w.query_y = unit(5); send_query(w);       // edge b-c
    w.query_x = -unit(2); w.query_y = -unit(2); send_query(w);     // corner tie
    w.query_x = unit(9); w.query_y = -unit(1); send_query(w);      // past b
    // degenerate: coincident vertices, collinear, tiny edge underflow
    w.vert_b_x = w.vert_a_x; w.vert_b_y = w.vert_a_y; send_query(w);
    w.vert_b_x = unit(2); w.vert_b_y = unit(2); w.vert_c_x = unit(4);
    w.vert_c_y = unit(4); send_query(w);
    w.vert_b_x = 32'sd1; w.vert_b_y = 0; w.vert_c_x = 0; w.vert_c_y = 32'sd1;
    send_query(w);
    // extremes: every field at max, min, zero, alternating
    send_query({12{FX_MAX}});
    send_query({12{FX_MIN}});
    send_query('0);
    send_query({6{FX_MAX, FX_MIN}});
    send_query({6{FX_MIN, FX_MAX}});
    send_query({12{32'h5555_5555}});
    send_query({12{32'hAAAA_AAAA}});
    w = '{FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MIN, FX_MIN,
          FX_MAX, FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MIN};
    send_query(w);                                   // saturating edges
    w = '{unit(0), unit(0), unit(10000), unit(-20000), unit(-20000), 0,
          unit(20000), unit(-20000), 0, 0, unit(20000), 0};
    send_query(w);                                   // huge triangle, overflow
  endtask

  // receiver: random stall, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(1, 100) <= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_word(out_word);
  end

  // watchdog: cycles with no accepted word on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (!sending_done || board.pending.size() != 0) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    sending_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();

    // idle mixes: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 25 : 0;
      for (int k = 0; k < 200; k++) send_query(rand_query());
    end

    // long receiver hold-off while the sender keeps pushing: fills the pipe
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int k = 0; k < 130; k++) send_query(rand_query());
    join
    in_valid <= 1'b0;

    sending_done = 1'b1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
rtl/cpt_pkg.sv
rtl/cpt_div.sv
rtl/closest_point_on_triangle.sv
rtl/cpt_checker.sv
tb/closest_point_on_triangle_test.sv
